### rtl/f2c_pkg.sv
`default_nettype none
package f2c_pkg;

    localparam int MAX_WAYPOINTS     = 256;
    localparam int CORDIC_ITERATIONS = 24;
    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int CFG_W = 9;
    localparam int N_W   = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam int DW    = 40;   // CORDIC x/y datapath
    localparam int ZW    = 36;   // CORDIC angle, Q6.30
    localparam int CW    = 33;   // multiplier operands
    localparam int AW    = 68;   // accumulator, Q16.46 with headroom

    localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);
    localparam logic signed [ZW-1:0] HALF_PI  = ZW'(64'sd1686629713);
    localparam logic signed [DW-1:0] INV_GAIN = DW'(64'sd652032874);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RD_PREV,
        S_RD_NEXT,
        S_VEC_INIT,
        S_VEC,
        S_ROT_INIT,
        S_ROT,
        S_MAC,
        S_OUT
    } t_state;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic clr;
        logic add;
        logic sub;
    } t_mac_ctl;

    typedef struct packed {
        logic load;
        logic step;
        logic rot;
    } t_cordic_ctl;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = ZW'(64'sd843314857);
            5'd1:  v = ZW'(64'sd497837829);
            5'd2:  v = ZW'(64'sd263043837);
            5'd3:  v = ZW'(64'sd133525159);
            5'd4:  v = ZW'(64'sd67021687);
            5'd5:  v = ZW'(64'sd33543516);
            5'd6:  v = ZW'(64'sd16775851);
            5'd7:  v = ZW'(64'sd8388437);
            5'd8:  v = ZW'(64'sd4194283);
            5'd9:  v = ZW'(64'sd2097149);
            5'd31: v = '0;
            default: v = ZW'(64'sd1) <<< (5'd30 - idx);
        endcase
        return v;
    endfunction

    // round half up from Q16.46 to Q16.16, then clamp
    function automatic logic signed [31:0] finish(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0]    r;
        logic signed [AW-31:0]   t;
        logic signed [31:0]      o;
        r = acc + AW'(64'sd536870912);
        t = (AW-30)'(r >>> 30);
        if (t > (AW-30)'(64'sd2147483647)) begin
            o = 32'sh7fffffff;
        end else if (t < -(AW-30)'(64'sd2147483648)) begin
            o = 32'sh80000000;
        end else begin
            o = t[31:0];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

### rtl/f2c_if.sv
`default_nettype none
interface f2c_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  wp_index;
    logic [31:0] wp_x;
    logic [31:0] wp_y;
    logic [30:0] wp_s;
    logic [30:0] query_s;
    logic [31:0] query_d;
    modport source (output valid, cmd, wp_index, wp_x, wp_y, wp_s, query_s, query_d,
                    input ready);
    modport sink   (input valid, cmd, wp_index, wp_x, wp_y, wp_s, query_s, query_d,
                    output ready);
endinterface

interface f2c_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    modport source (output valid, out_x, out_y, input ready);
    modport sink   (input valid, out_x, out_y, output ready);
endinterface
`default_nettype wire

### rtl/f2c_tables.sv
`default_nettype none
module f2c_tables import f2c_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [31:0]      i_wx,
    input  wire logic [31:0]      i_wy,
    input  wire logic [30:0]      i_ws,
    input  wire logic [IDX_W-1:0] i_raddr,
    output logic [31:0]           o_rx,
    output logic [31:0]           o_ry,
    output logic [30:0]           o_rs
);
    logic [31:0] r_xmem [MAX_WAYPOINTS];
    logic [31:0] r_ymem [MAX_WAYPOINTS];
    logic [30:0] r_smem [MAX_WAYPOINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_xmem[i_waddr] <= i_wx;
            r_ymem[i_waddr] <= i_wy;
            r_smem[i_waddr] <= i_ws;
        end
        o_rx <= r_xmem[i_raddr];
        o_ry <= r_ymem[i_raddr];
        o_rs <= r_smem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/f2c_cordic.sv
`default_nettype none
module f2c_cordic import f2c_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_cordic_ctl        i_ctl,
    input  wire logic [4:0]         i_iter,
    input  wire logic signed [DW-1:0] i_x,
    input  wire logic signed [DW-1:0] i_y,
    input  wire logic signed [ZW-1:0] i_z,
    output logic signed [DW-1:0]    o_x,
    output logic signed [DW-1:0]    o_y,
    output logic signed [ZW-1:0]    o_z
);
    logic signed [DW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 pos;

    always_comb begin
        xs  = o_x >>> i_iter;
        ys  = o_y >>> i_iter;
        at  = atan_q30(i_iter);
        // vectoring drives y to zero, rotation drives z to zero
        pos = i_ctl.rot ? (o_z < 0) : (o_y >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            o_x <= i_x;
            o_y <= i_y;
            o_z <= i_z;
        end else if (i_ctl.step) begin
            if (pos) begin
                o_x <= o_x + ys;
                o_y <= o_y - xs;
                o_z <= o_z + at;
            end else begin
                o_x <= o_x - ys;
                o_y <= o_y + xs;
                o_z <= o_z - at;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/f2c_mac.sv
`default_nettype none
module f2c_mac import f2c_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_mac_ctl           i_ctl,
    input  wire logic signed [AW-1:0] i_init,
    input  wire logic signed [CW-1:0] i_a,
    input  wire logic signed [CW-1:0] i_b,
    output logic signed [AW-1:0]    o_acc
);
    logic signed [2*CW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.clr) begin
            o_acc <= i_init;
        end else if (i_ctl.add) begin
            o_acc <= o_acc + AW'(r_prod);
        end else if (i_ctl.sub) begin
            o_acc <= o_acc - AW'(r_prod);
        end
    end
endmodule
`default_nettype wire

### rtl/frenet_to_cartesian_top.sv
// Frenet to Cartesian conversion over a closed-loop waypoint map.
// Input channel i_in carries two kinds of item: cmd load writes x, y and s of
// one waypoint into the tables; cmd query gives (query_s, query_d) and
// yields one result (out_x, out_y) on o_out. Loads yield nothing.
// i_cfg_we/i_cfg_wdata set the number of waypoints in use (0 acts as 1).
// A query runs a linear scan of the s table (a read state and a compare
// state per entry, one memory read port), two table reads, a vectoring
// CORDIC and a rotation CORDIC of CORDIC_ITERATIONS steps each plus a
// setup state each, then the multiply-accumulate steps for x and then y on
// the shared multiplier-accumulator and an output state.
// i_in.ready is high only when no query is in flight.
// The result sits in an output register; a new item is taken while it waits,
// but the next query holds in its output cycle until the receiver takes it.
// Synchronous reset clears the sequencer, the output valid and sets the
// waypoint count to 1; table contents are undefined until loaded.
`default_nettype none
module frenet_to_cartesian_top import f2c_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    f2c_in_if.sink        i_in,
    f2c_out_if.source     o_out,
    input  wire logic     i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);
    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_wp_count;
    logic [N_W-1:0]    n_eff;
    logic [N_W-1:0]    r_i;
    logic [IDX_W-1:0]  r_prev, nxt;
    logic [30:0]       r_qs, r_s0;
    logic [31:0]       r_qd, r_x0, r_y0;
    logic [4:0]        r_iter;
    logic [2:0]        r_mstep;
    logic              r_zero, r_qpos, r_qneg;
    logic [31:0]       r_px, r_py;
    logic              r_ovalid;
    logic [31:0]       r_ox, r_oy;

    logic              in_acc, tbl_we;
    logic [IDX_W-1:0]  raddr;
    logic [31:0]       rx, ry;
    logic [30:0]       rs;
    logic              hit, out_free;

    t_cordic_ctl       cctl;
    logic signed [DW-1:0] cx_in, cy_in, cx, cy;
    logic signed [ZW-1:0] cz_in, cz;
    logic signed [32:0]   dx, dy;
    logic signed [DW-1:0] dxw, dyw;
    logic signed [ZW-1:0] ang;

    t_mac_ctl          mctl;
    logic signed [AW-1:0] minit, acc;
    logic signed [CW-1:0] ma, mb, cosv, sinv, segv, qdv;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign tbl_we      = in_acc && (i_in.cmd == CMD_LOAD)
                         && (N_W'(i_in.wp_index) < N_W'(MAX_WAYPOINTS));
    assign o_out.valid = r_ovalid;
    assign o_out.out_x = r_ox;
    assign o_out.out_y = r_oy;
    assign out_free    = !r_ovalid || o_out.ready;

    always_comb begin
        if (r_wp_count == '0) begin
            n_eff = N_W'(1);
        end else if (N_W'(r_wp_count) > N_W'(MAX_WAYPOINTS)) begin
            n_eff = N_W'(MAX_WAYPOINTS);
        end else begin
            n_eff = N_W'(r_wp_count);
        end
        nxt = (N_W'(r_prev) + N_W'(1) == n_eff) ? '0 : r_prev + IDX_W'(1);
        hit = r_qs > rs;
    end

    f2c_tables u_tables (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (IDX_W'(i_in.wp_index)),
        .i_wx    (i_in.wp_x),
        .i_wy    (i_in.wp_y),
        .i_ws    (i_in.wp_s),
        .i_raddr (raddr),
        .o_rx    (rx),
        .o_ry    (ry),
        .o_rs    (rs)
    );

    f2c_cordic u_cordic (
        .i_clk  (i_clk),
        .i_ctl  (cctl),
        .i_iter (r_iter),
        .i_x    (cx_in),
        .i_y    (cy_in),
        .i_z    (cz_in),
        .o_x    (cx),
        .o_y    (cy),
        .o_z    (cz)
    );

    f2c_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mctl),
        .i_init (minit),
        .i_a    (ma),
        .i_b    (mb),
        .o_acc  (acc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_acc && i_in.cmd == CMD_QUERY) n_state = S_SCAN_RD;
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (hit && (r_i + N_W'(1) < n_eff)) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_RD_PREV;
                end
            end
            S_RD_PREV:  n_state = S_RD_NEXT;
            S_RD_NEXT:  n_state = S_VEC_INIT;
            S_VEC_INIT: n_state = S_VEC;
            S_VEC:      if (r_iter == ITER_LAST) n_state = S_ROT_INIT;
            S_ROT_INIT: n_state = S_ROT;
            S_ROT:      if (r_iter == ITER_LAST) n_state = S_MAC;
            S_MAC:      if (r_mstep == 3'd6) n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        raddr = r_prev;
        cctl  = '0;
        cx_in = '0;
        cy_in = '0;
        cz_in = '0;
        mctl  = '0;
        minit = '0;
        ma    = '0;
        mb    = '0;
        dx    = 33'($signed(rx)) - 33'($signed(r_x0));
        dy    = 33'($signed(ry)) - 33'($signed(r_y0));
        dxw   = DW'(dx);
        dyw   = DW'(dy);
        ang   = r_zero ? '0 : cz;
        // undo the quadrant fold of the rotation
        if (r_qpos) begin
            cosv = CW'(-cy);
            sinv = CW'(cx);
        end else if (r_qneg) begin
            cosv = CW'(cy);
            sinv = CW'(-cx);
        end else begin
            cosv = CW'(cx);
            sinv = CW'(cy);
        end
        segv = CW'($signed({1'b0, r_qs}) - $signed({1'b0, r_s0}));
        qdv  = CW'($signed(r_qd));
        unique case (r_state)
            S_SCAN_RD: raddr = r_i[IDX_W-1:0];
            S_RD_NEXT: raddr = nxt;
            S_VEC_INIT: begin
                cctl.load = 1'b1;
                if (dx < 0) begin
                    if (dy >= 0) begin
                        cx_in = dyw;
                        cy_in = -dxw;
                        cz_in = HALF_PI;
                    end else begin
                        cx_in = -dyw;
                        cy_in = dxw;
                        cz_in = -HALF_PI;
                    end
                end else begin
                    cx_in = dxw;
                    cy_in = dyw;
                end
            end
            S_VEC: cctl.step = 1'b1;
            S_ROT_INIT: begin
                cctl.load = 1'b1;
                cctl.rot  = 1'b1;
                cx_in     = INV_GAIN;
                if (ang > HALF_PI) begin
                    cz_in = ang - HALF_PI;
                end else if (ang < -HALF_PI) begin
                    cz_in = ang + HALF_PI;
                end else begin
                    cz_in = ang;
                end
            end
            S_ROT: begin
                cctl.step = 1'b1;
                cctl.rot  = 1'b1;
            end
            S_MAC: begin
                unique case (r_mstep)
                    3'd0: begin
                        mctl.clr = 1'b1;
                        minit    = AW'($signed(r_x0)) <<< 30;
                        ma = segv;
                        mb = cosv;
                    end
                    3'd1: begin
                        mctl.add = 1'b1;
                        ma = qdv;
                        mb = sinv;
                    end
                    3'd2: mctl.add = 1'b1;
                    3'd3: begin
                        mctl.clr = 1'b1;
                        minit    = AW'($signed(r_y0)) <<< 30;
                        ma = segv;
                        mb = sinv;
                    end
                    3'd4: begin
                        mctl.add = 1'b1;
                        ma = qdv;
                        mb = cosv;
                    end
                    3'd5: mctl.sub = 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp_count <= CFG_W'(1);
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_wp_count <= i_cfg_wdata;
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qs   <= i_in.query_s;
                r_qd   <= i_in.query_d;
                r_i    <= '0;
                r_prev <= '0;
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    r_prev <= r_i[IDX_W-1:0];
                    r_i    <= r_i + N_W'(1);
                end
            end
            S_RD_NEXT: begin
                r_x0 <= rx;
                r_y0 <= ry;
                r_s0 <= rs;
            end
            S_VEC_INIT: begin
                r_zero <= (dx == 0) && (dy == 0);
                r_iter <= '0;
            end
            S_ROT_INIT: begin
                r_qpos <= ang > HALF_PI;
                r_qneg <= ang < -HALF_PI;
                r_iter <= '0;
            end
            S_VEC, S_ROT: begin
                r_iter  <= r_iter + 5'd1;
                r_mstep <= '0;
            end
            S_MAC: begin
                r_mstep <= r_mstep + 3'd1;
                if (r_mstep == 3'd3) r_px <= finish(acc);
                if (r_mstep == 3'd6) r_py <= finish(acc);
            end
            S_OUT: begin
                if (out_free) begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### rtl/f2c_checker.sv
`default_nettype none
module f2c_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_cmd,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_x,
    input wire logic [31:0] out_y
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && !in_cmd && !out_valid |=> !out_valid)
        else $error("load produced a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_cmd |=> !in_ready)
        else $error("input taken during a query");
endmodule

bind frenet_to_cartesian_top f2c_checker u_f2c_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_cmd    (i_in.cmd),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_x     (o_out.out_x),
    .out_y     (o_out.out_y)
);
`default_nettype wire
